### hw/rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 9;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int WIDE_W    = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_READ       = 3'd5,
        CMD_RESIZE     = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SEARCH,
        ST_FILL,
        ST_RESP
    } state_t;

endpackage

### hw/rtl/bdq_ram.sv
module bdq_ram #(
    parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF,
    parameter int AW        = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/bounded_deque_with_search_top.sv
// Channel  Direction  Ports                                       Transaction
// s_       in         s_cmd, s_value, s_position                  one command
// m_       out        m_found, m_read_data, m_count, m_status     one result per command
//
// Push, pop, clear and rejected commands pass through the execute and response states before the result is registered.
// A read also passes through a read-wait state, because the read data of the ring memory is registered.
// A search reads one entry per cycle and stops early on a hit.
// A growing resize writes one zero per cycle into the new slots.
// Reset is synchronous and active low; the memory contents are not cleared.
// A result waits in the output register while the next command is accepted.
module bounded_deque_with_search_top #(
    parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bdq_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  s_value,
    input  logic [bdq_pkg::POS_W-1:0]           s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic signed [bdq_pkg::VALUE_W-1:0]  m_read_data,
    output logic [bdq_pkg::COUNT_W-1:0]         m_count,
    output logic [bdq_pkg::STATUS_W-1:0]        m_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int XW = ((CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W) + 1;
    localparam logic [XW-1:0] DEPTH_X   = XW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    bdq_pkg::state_t  state_reg, state_next;
    bdq_pkg::cmd_t    cmd_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [bdq_pkg::POS_W-1:0] pos_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic [WORD_BITS-1:0] rdata_reg, rdata_next;
    bdq_pkg::status_t status_reg, status_next;

    logic             m_valid_reg;
    logic             m_found_reg;
    logic [bdq_pkg::VALUE_W-1:0]  m_read_data_reg;
    logic [bdq_pkg::COUNT_W-1:0]  m_count_reg;
    logic [bdq_pkg::STATUS_W-1:0] m_status_reg;

    logic signed [bdq_pkg::WIDE_W-1:0] value_wide;
    logic [bdq_pkg::WIDE_W-1:0] rdata_wide;
    logic [XW-1:0]    count_x, pos_x, idx_x;
    logic [CW-1:0]    offset;
    logic [SW-1:0]    slot_sum;
    logic [AW-1:0]    slot;
    logic [AW-1:0]    head_dec;
    logic             accept;
    logic             out_load;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic             ram_re;
    logic [WORD_BITS-1:0] ram_rdata;

    assign value_wide = bdq_pkg::WIDE_W'(s_value);
    assign rdata_wide = bdq_pkg::WIDE_W'(rdata_reg);
    assign count_x    = XW'(count_reg);
    assign pos_x      = XW'(pos_reg);
    assign idx_x      = XW'(idx_reg);
    assign head_dec   = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);

    always_comb begin
        if (state_reg == bdq_pkg::ST_EXEC && cmd_reg == bdq_pkg::CMD_READ) begin
            offset = pos_x[CW-1:0];
        end else if (state_reg == bdq_pkg::ST_EXEC) begin
            offset = count_reg;
        end else begin
            offset = idx_reg;
        end
        slot_sum = SW'(head_reg) + SW'(offset);
        if (slot_sum >= DEPTH_S) begin
            slot = AW'(slot_sum - DEPTH_S);
        end else begin
            slot = AW'(slot_sum);
        end
    end

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == bdq_pkg::ST_RESP) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        found_next  = found_reg;
        rdata_next  = rdata_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = slot;
        ram_wdata   = word_reg;
        ram_re      = 1'b0;
        s_ready     = 1'b0;
        case (state_reg)
            bdq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next  = bdq_pkg::ST_EXEC;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    rdata_next  = '0;
                    status_next = bdq_pkg::STATUS_OK;
                end
            end
            bdq_pkg::ST_EXEC: begin
                state_next = bdq_pkg::ST_RESP;
                case (cmd_reg)
                    bdq_pkg::CMD_PUSH_BACK: begin
                        if (count_x >= DEPTH_X) begin
                            status_next = bdq_pkg::STATUS_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    bdq_pkg::CMD_PUSH_FRONT: begin
                        if (count_x >= DEPTH_X) begin
                            status_next = bdq_pkg::STATUS_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    bdq_pkg::CMD_POP_BACK: begin
                        if (count_reg != '0) begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    bdq_pkg::CMD_POP_FRONT: begin
                        if (count_reg != '0) begin
                            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
                            count_next = count_reg - CW'(1);
                        end
                    end
                    bdq_pkg::CMD_SEARCH: begin
                        state_next = bdq_pkg::ST_SEARCH;
                    end
                    bdq_pkg::CMD_READ: begin
                        if (pos_x >= count_x) begin
                            status_next = bdq_pkg::STATUS_RANGE;
                        end else begin
                            ram_re     = 1'b1;
                            state_next = bdq_pkg::ST_READ_WAIT;
                        end
                    end
                    bdq_pkg::CMD_RESIZE: begin
                        if (pos_x > DEPTH_X) begin
                            status_next = bdq_pkg::STATUS_RANGE;
                        end else begin
                            idx_next   = count_reg;
                            state_next = bdq_pkg::ST_FILL;
                        end
                    end
                    bdq_pkg::CMD_CLEAR: begin
                        count_next = '0;
                        head_next  = '0;
                    end
                    default: begin
                        state_next = bdq_pkg::ST_RESP;
                    end
                endcase
            end
            bdq_pkg::ST_READ_WAIT: begin
                rdata_next = ram_rdata;
                state_next = bdq_pkg::ST_RESP;
            end
            bdq_pkg::ST_SEARCH: begin
                if (pend_reg && ram_rdata == word_reg) begin
                    found_next = 1'b1;
                    state_next = bdq_pkg::ST_RESP;
                end else if (idx_reg < count_reg) begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end else if (!pend_reg) begin
                    state_next = bdq_pkg::ST_RESP;
                end
            end
            bdq_pkg::ST_FILL: begin
                if (idx_x < pos_x) begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                    idx_next  = idx_reg + CW'(1);
                end else begin
                    count_next = pos_x[CW-1:0];
                    state_next = bdq_pkg::ST_RESP;
                end
            end
            bdq_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = bdq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdq_pkg::ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= bdq_pkg::cmd_t'(s_cmd);
            word_reg <= value_wide[WORD_BITS-1:0];
            pos_reg  <= s_position;
        end
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        rdata_reg  <= rdata_next;
        status_reg <= status_next;
        if (out_load) begin
            m_found_reg     <= found_reg;
            m_read_data_reg <= rdata_wide[bdq_pkg::VALUE_W-1:0];
            m_count_reg     <= bdq_pkg::COUNT_W'(count_reg);
            m_status_reg    <= status_reg;
        end
    end

    bdq_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_read_data = m_read_data_reg;
    assign m_count     = m_count_reg;
    assign m_status    = m_status_reg;

endmodule

### hw/rtl/bdq_checker.sv
module bdq_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_found,
    input logic signed [bdq_pkg::VALUE_W-1:0]  m_read_data,
    input logic [bdq_pkg::COUNT_W-1:0]         m_count,
    input logic [bdq_pkg::STATUS_W-1:0]        m_status
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("Reset did not leave the block idle with no result.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A second transaction was accepted while one was in progress.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_status)
            && $stable(m_found) && $stable(m_read_data))
        else $error("A stalled result changed before it was taken.");

    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_status == bdq_pkg::STATUS_OK && m_count != '0
            && m_read_data == '0)
        else $error("A search hit came with an error, an empty queue or read data.");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != bdq_pkg::STATUS_OK |-> !m_found && m_read_data == '0)
        else $error("A refused command returned a hit or read data.");

endmodule

bind bounded_deque_with_search_top bdq_checker u_bdq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_found     (m_found),
    .m_read_data (m_read_data),
    .m_count     (m_count),
    .m_status    (m_status)
);
